// ----- rtl/kfpu_pkg.sv -----
// kfpu_pkg: types, codes, saturation helper and microcode rom for the
// two-state kalman filter unit. no dependencies.
package kfpu_pkg;

  localparam logic [1:0] ACT_PREDICT = 2'd0;
  localparam logic [1:0] ACT_UPDATE  = 2'd1;
  localparam logic [1:0] ACT_INIT    = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [2:0] CFG_TRANS_ROW0 = 3'd0;
  localparam logic [2:0] CFG_TRANS_ROW1 = 3'd1;
  localparam logic [2:0] CFG_PNOISE_ROW0 = 3'd2;
  localparam logic [2:0] CFG_PNOISE_ROW1 = 3'd3;
  localparam logic [2:0] CFG_MEAS_ROW   = 3'd4;
  localparam logic [2:0] CFG_MEAS_NOISE = 3'd5;

  localparam int unsigned PcW = 7;
  localparam logic [PcW-1:0] ADDR_PREDICT = 7'd0;
  localparam logic [PcW-1:0] ADDR_UPDATE  = 7'd42;
  localparam logic [PcW-1:0] ADDR_ZEND    = 7'd89;
  localparam logic [PcW-1:0] ADDR_INIT    = 7'd90;
  localparam logic [PcW-1:0] ADDR_NONE    = 7'd96;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] meas_value;
    logic signed [31:0] init_est_0;
    logic signed [31:0] init_est_1;
    logic signed [31:0] init_cov_00;
    logic signed [31:0] init_cov_01;
    logic signed [31:0] init_cov_10;
    logic signed [31:0] init_cov_11;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         step_kind;
    logic signed [31:0] residual;
    logic signed [31:0] est_out_0;
    logic signed [31:0] est_out_1;
    logic signed [31:0] cov_out_00;
    logic signed [31:0] cov_out_01;
    logic signed [31:0] cov_out_10;
    logic signed [31:0] cov_out_11;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN
  } state_e;

  typedef enum logic [3:0] {
    U_NOP,
    U_LD,
    U_ACC,
    U_DOTADD,
    U_DOTSUB,
    U_ADDF,
    U_SUBF,
    U_DIV,
    U_MOV,
    U_JZ,
    U_END
  } uop_e;

  typedef enum logic [5:0] {
    R_ZERO,
    R_X0, R_X1, R_P00, R_P01, R_P10, R_P11,
    R_F00, R_F01, R_F10, R_F11,
    R_Q00, R_Q01, R_Q10, R_Q11,
    R_H0, R_H1, R_R, R_Z, R_Y,
    R_T0, R_T1, R_T2, R_T3, R_T4, R_T5, R_T6, R_T7,
    R_IE0, R_IE1, R_IC00, R_IC01, R_IC10, R_IC11
  } reg_e;

  typedef struct packed {
    logic           mul;
    uop_e           op;
    reg_e           a;
    reg_e           b;
    reg_e           dst;
    logic [PcW-1:0] tgt;
  } uword_t;

  localparam uword_t UW_NOP = '{mul: 1'b0, op: U_NOP, a: R_ZERO, b: R_ZERO,
                                dst: R_ZERO, tgt: '0};

  // saturate a wide signed value to 32 bits, bit 32 flags a clip
  function automatic logic [32:0] sat32(input logic signed [49:0] v);
    logic [32:0] r;
    if (v > 50'sd2147483647) begin
      r = {1'b1, 32'h7fffffff};
    end else if (v < -50'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic uword_t uw(input logic m, input uop_e o, input reg_e a,
                                input reg_e b, input reg_e d);
    uword_t w;
    w = '{mul: m, op: o, a: a, b: b, dst: d, tgt: '0};
    return w;
  endfunction

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t u;
    u = uw(1'b0, U_END, R_ZERO, R_ZERO, R_ZERO);
    unique case (pc)
      // predict: x = F x
      7'd0:  u = uw(1'b1, U_NOP, R_F00, R_X0, R_ZERO);
      7'd1:  u = uw(1'b1, U_LD, R_F01, R_X1, R_ZERO);
      7'd2:  u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd3:  u = uw(1'b0, U_DOTADD, R_ZERO, R_ZERO, R_T0);
      7'd4:  u = uw(1'b1, U_NOP, R_F10, R_X0, R_ZERO);
      7'd5:  u = uw(1'b1, U_LD, R_F11, R_X1, R_ZERO);
      7'd6:  u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd7:  u = uw(1'b0, U_DOTADD, R_ZERO, R_ZERO, R_X1);
      // a = F P
      7'd8:  u = uw(1'b1, U_NOP, R_F00, R_P00, R_ZERO);
      7'd9:  u = uw(1'b1, U_LD, R_F01, R_P10, R_ZERO);
      7'd10: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd11: u = uw(1'b0, U_DOTADD, R_ZERO, R_ZERO, R_T1);
      7'd12: u = uw(1'b1, U_NOP, R_F00, R_P01, R_ZERO);
      7'd13: u = uw(1'b1, U_LD, R_F01, R_P11, R_ZERO);
      7'd14: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd15: u = uw(1'b0, U_DOTADD, R_ZERO, R_ZERO, R_T2);
      7'd16: u = uw(1'b1, U_NOP, R_F10, R_P00, R_ZERO);
      7'd17: u = uw(1'b1, U_LD, R_F11, R_P10, R_ZERO);
      7'd18: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd19: u = uw(1'b0, U_DOTADD, R_ZERO, R_ZERO, R_T3);
      7'd20: u = uw(1'b1, U_NOP, R_F10, R_P01, R_ZERO);
      7'd21: u = uw(1'b1, U_LD, R_F11, R_P11, R_ZERO);
      7'd22: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd23: u = uw(1'b0, U_DOTADD, R_ZERO, R_ZERO, R_T4);
      // P = a F' + Q
      7'd24: u = uw(1'b1, U_NOP, R_T1, R_F00, R_ZERO);
      7'd25: u = uw(1'b1, U_LD, R_T2, R_F01, R_ZERO);
      7'd26: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd27: u = uw(1'b0, U_DOTADD, R_ZERO, R_Q00, R_P00);
      7'd28: u = uw(1'b1, U_NOP, R_T1, R_F10, R_ZERO);
      7'd29: u = uw(1'b1, U_LD, R_T2, R_F11, R_ZERO);
      7'd30: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd31: u = uw(1'b0, U_DOTADD, R_ZERO, R_Q01, R_P01);
      7'd32: u = uw(1'b1, U_NOP, R_T3, R_F00, R_ZERO);
      7'd33: u = uw(1'b1, U_LD, R_T4, R_F01, R_ZERO);
      7'd34: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd35: u = uw(1'b0, U_DOTADD, R_ZERO, R_Q10, R_P10);
      7'd36: u = uw(1'b1, U_NOP, R_T3, R_F10, R_ZERO);
      7'd37: u = uw(1'b1, U_LD, R_T4, R_F11, R_ZERO);
      7'd38: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd39: u = uw(1'b0, U_DOTADD, R_ZERO, R_Q11, R_P11);
      7'd40: u = uw(1'b0, U_MOV, R_T0, R_ZERO, R_X0);
      7'd41: u = uw(1'b0, U_END, R_ZERO, R_ZERO, R_ZERO);
      // update: y = z - H x
      7'd42: u = uw(1'b1, U_NOP, R_H0, R_X0, R_ZERO);
      7'd43: u = uw(1'b1, U_LD, R_H1, R_X1, R_ZERO);
      7'd44: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd45: u = uw(1'b0, U_DOTSUB, R_Z, R_ZERO, R_Y);
      // P H'
      7'd46: u = uw(1'b1, U_NOP, R_P00, R_H0, R_ZERO);
      7'd47: u = uw(1'b1, U_LD, R_P01, R_H1, R_ZERO);
      7'd48: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd49: u = uw(1'b0, U_DOTADD, R_ZERO, R_ZERO, R_T1);
      7'd50: u = uw(1'b1, U_NOP, R_P10, R_H0, R_ZERO);
      7'd51: u = uw(1'b1, U_LD, R_P11, R_H1, R_ZERO);
      7'd52: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd53: u = uw(1'b0, U_DOTADD, R_ZERO, R_ZERO, R_T2);
      // H P
      7'd54: u = uw(1'b1, U_NOP, R_H0, R_P00, R_ZERO);
      7'd55: u = uw(1'b1, U_LD, R_H1, R_P10, R_ZERO);
      7'd56: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd57: u = uw(1'b0, U_DOTADD, R_ZERO, R_ZERO, R_T3);
      7'd58: u = uw(1'b1, U_NOP, R_H0, R_P01, R_ZERO);
      7'd59: u = uw(1'b1, U_LD, R_H1, R_P11, R_ZERO);
      7'd60: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd61: u = uw(1'b0, U_DOTADD, R_ZERO, R_ZERO, R_T4);
      // S = H P H' + R
      7'd62: u = uw(1'b1, U_NOP, R_H0, R_T1, R_ZERO);
      7'd63: u = uw(1'b1, U_LD, R_H1, R_T2, R_ZERO);
      7'd64: u = uw(1'b0, U_ACC, R_ZERO, R_ZERO, R_ZERO);
      7'd65: u = uw(1'b0, U_DOTADD, R_ZERO, R_R, R_T6);
      7'd66: u = uw(1'b0, U_NOP, R_ZERO, R_ZERO, R_ZERO);
      7'd67: begin
        u = uw(1'b0, U_JZ, R_T6, R_ZERO, R_ZERO);
        u.tgt = ADDR_ZEND;
      end
      // gains
      7'd68: u = uw(1'b0, U_DIV, R_T1, R_T6, R_T7);
      7'd69: u = uw(1'b0, U_DIV, R_T2, R_T6, R_T5);
      // x += K y
      7'd70: u = uw(1'b1, U_NOP, R_T7, R_Y, R_ZERO);
      7'd71: u = uw(1'b0, U_LD, R_ZERO, R_ZERO, R_ZERO);
      7'd72: u = uw(1'b0, U_ADDF, R_X0, R_ZERO, R_X0);
      7'd73: u = uw(1'b1, U_NOP, R_T5, R_Y, R_ZERO);
      7'd74: u = uw(1'b0, U_LD, R_ZERO, R_ZERO, R_ZERO);
      7'd75: u = uw(1'b0, U_ADDF, R_X1, R_ZERO, R_X1);
      // P -= K H P
      7'd76: u = uw(1'b1, U_NOP, R_T7, R_T3, R_ZERO);
      7'd77: u = uw(1'b0, U_LD, R_ZERO, R_ZERO, R_ZERO);
      7'd78: u = uw(1'b0, U_SUBF, R_P00, R_ZERO, R_P00);
      7'd79: u = uw(1'b1, U_NOP, R_T7, R_T4, R_ZERO);
      7'd80: u = uw(1'b0, U_LD, R_ZERO, R_ZERO, R_ZERO);
      7'd81: u = uw(1'b0, U_SUBF, R_P01, R_ZERO, R_P01);
      7'd82: u = uw(1'b1, U_NOP, R_T5, R_T3, R_ZERO);
      7'd83: u = uw(1'b0, U_LD, R_ZERO, R_ZERO, R_ZERO);
      7'd84: u = uw(1'b0, U_SUBF, R_P10, R_ZERO, R_P10);
      7'd85: u = uw(1'b1, U_NOP, R_T5, R_T4, R_ZERO);
      7'd86: u = uw(1'b0, U_LD, R_ZERO, R_ZERO, R_ZERO);
      7'd87: u = uw(1'b0, U_SUBF, R_P11, R_ZERO, R_P11);
      7'd88: u = uw(1'b0, U_END, R_ZERO, R_ZERO, R_ZERO);
      7'd89: u = uw(1'b0, U_END, R_ZERO, R_ZERO, R_ZERO);
      // initialise
      7'd90: u = uw(1'b0, U_MOV, R_IE0, R_ZERO, R_X0);
      7'd91: u = uw(1'b0, U_MOV, R_IE1, R_ZERO, R_X1);
      7'd92: u = uw(1'b0, U_MOV, R_IC00, R_ZERO, R_P00);
      7'd93: u = uw(1'b0, U_MOV, R_IC01, R_ZERO, R_P01);
      7'd94: u = uw(1'b0, U_MOV, R_IC10, R_ZERO, R_P10);
      7'd95: u = uw(1'b0, U_MOV, R_IC11, R_ZERO, R_P11);
      default: u = uw(1'b0, U_END, R_ZERO, R_ZERO, R_ZERO);
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/kfpu_div.sv -----
// kfpu_div: radix-2 restoring divider for the gain, (num * 65536) / den
// truncated toward zero and saturated to 32 bits. uses kfpu_pkg.
module kfpu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic        sat_o
);
  import kfpu_pkg::*;

  localparam int unsigned DvdW = 48;
  localparam int unsigned CntW = $clog2(DvdW);

  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q, neg_q;
  logic [31:0]     rem_q, dsr_q;
  logic [DvdW-1:0] dvd_q;
  logic [32:0]     sh, diff;
  logic            qbit;
  logic [31:0]     num_mag, den_mag;

  assign num_mag = num_i[31] ? (32'd0 - num_i) : num_i;
  assign den_mag = den_i[31] ? (32'd0 - den_i) : den_i;
  assign sh      = {rem_q, dvd_q[DvdW-1]};
  assign diff    = sh - {1'b0, dsr_q};
  assign qbit    = (sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DvdW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_mag, 16'd0};
      dsr_q <= den_mag;
      rem_q <= '0;
      neg_q <= num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      rem_q <= qbit ? diff[31:0] : sh[31:0];
      dvd_q <= {dvd_q[DvdW-2:0], qbit};
    end
  end

  // quotient magnitude sits in dvd_q once done
  always_comb begin
    sat_o = 1'b0;
    quo_o = 32'd0 - dvd_q[31:0];
    if (neg_q) begin
      if (dvd_q > 48'h0000_8000_0000) begin
        sat_o = 1'b1;
        quo_o = 32'h8000_0000;
      end
    end else begin
      quo_o = dvd_q[31:0];
      if (dvd_q > 48'h0000_7fff_ffff) begin
        sat_o = 1'b1;
        quo_o = 32'h7fff_ffff;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ----- rtl/kalman_filter_predict_update_unit.sv -----
// kalman filter unit: one item at a time, run by the microcode program
// on the single shared 32x32 multiplier and the divider; an update uses
// two divisions, which are skipped when S is zero.
// reset: F and H identity-like, Q and R zero, x zero, P identity.
module kalman_filter_predict_update_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kfpu_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kfpu_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);
  import kfpu_pkg::*;

  state_e state_q, state_d;
  logic   in_acc, run, ex_stall, jump, div_start, div_busy, div_done, div_sat;
  logic [31:0] div_quo;

  logic [PcW-1:0] pc_q;
  uword_t         ex_q, fw;
  logic [31:0]    opa_q, opb_q, opa_d, opb_d;
  logic signed [63:0] prod_q, acc_q;
  logic           started_q, sat_q, zero_q;
  in_item_t       in_q;
  out_item_t      out_q;
  logic           out_valid_q;

  logic [3:0][31:0] f_q, q_q;
  logic [1:0][31:0] h_q, x_q;
  logic [3:0][31:0] p_q;
  logic [7:0][31:0] t_q;
  logic [31:0]      r_q, y_q;

  // ---- control fsm
  assign in_acc = in_valid_i && !in_stall_o;
  assign run    = (state_q == S_RUN);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_RUN;
      S_RUN:   if (ex_q.op == U_END) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_q)
      S_IDLE:  in_stall_o = out_valid_q && out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- operand fetch
  assign fw = ucode(pc_q);

  function automatic logic [31:0] rd(input reg_e c, input logic [3:0][31:0] f,
                                     input logic [3:0][31:0] q,
                                     input logic [1:0][31:0] h,
                                     input logic [1:0][31:0] x,
                                     input logic [3:0][31:0] p,
                                     input logic [7:0][31:0] t,
                                     input logic [31:0] r, input logic [31:0] y,
                                     input in_item_t it);
    logic [31:0] v;
    v = '0;
    unique case (c)
      R_X0:   v = x[0];
      R_X1:   v = x[1];
      R_P00:  v = p[0];
      R_P01:  v = p[1];
      R_P10:  v = p[2];
      R_P11:  v = p[3];
      R_F00:  v = f[0];
      R_F01:  v = f[1];
      R_F10:  v = f[2];
      R_F11:  v = f[3];
      R_Q00:  v = q[0];
      R_Q01:  v = q[1];
      R_Q10:  v = q[2];
      R_Q11:  v = q[3];
      R_H0:   v = h[0];
      R_H1:   v = h[1];
      R_R:    v = r;
      R_Z:    v = it.meas_value;
      R_Y:    v = y;
      R_T0:   v = t[0];
      R_T1:   v = t[1];
      R_T2:   v = t[2];
      R_T3:   v = t[3];
      R_T4:   v = t[4];
      R_T5:   v = t[5];
      R_T6:   v = t[6];
      R_T7:   v = t[7];
      R_IE0:  v = it.init_est_0;
      R_IE1:  v = it.init_est_1;
      R_IC00: v = it.init_cov_00;
      R_IC01: v = it.init_cov_01;
      R_IC10: v = it.init_cov_10;
      R_IC11: v = it.init_cov_11;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign opa_d = rd(fw.a, f_q, q_q, h_q, x_q, p_q, t_q, r_q, y_q, in_q);
  assign opb_d = rd(fw.b, f_q, q_q, h_q, x_q, p_q, t_q, r_q, y_q, in_q);

  // ---- execute
  assign ex_stall  = (ex_q.op == U_DIV) && !div_done;
  assign jump      = (ex_q.op == U_JZ) && (opa_q == 32'd0);
  assign div_start = run && (ex_q.op == U_DIV) && !started_q;

  logic signed [47:0] fl;
  logic [32:0] tsat, res;
  logic        wr_en;
  logic signed [64:0] sum65;

  assign fl    = acc_q[63:16];
  assign tsat  = sat32({{2{fl[47]}}, fl});
  assign sum65 = {acc_q[63], acc_q} + {prod_q[63], prod_q};

  always_comb begin
    res   = '0;
    wr_en = 1'b0;
    case (ex_q.op)
      U_DOTADD: begin
        res   = sat32(50'($signed(tsat[31:0])) + 50'($signed(opb_q)));
        res[32] = res[32] | tsat[32];
        wr_en = 1'b1;
      end
      U_DOTSUB: begin
        res   = sat32(50'($signed(opa_q)) - 50'($signed(tsat[31:0])));
        res[32] = res[32] | tsat[32];
        wr_en = 1'b1;
      end
      U_ADDF: begin
        res   = sat32(50'($signed(opa_q)) + 50'(fl));
        wr_en = 1'b1;
      end
      U_SUBF: begin
        res   = sat32(50'($signed(opa_q)) - 50'(fl));
        wr_en = 1'b1;
      end
      U_MOV: begin
        res   = {1'b0, opa_q};
        wr_en = 1'b1;
      end
      U_DIV: begin
        res   = {div_sat, div_quo};
        wr_en = div_done;
      end
      default: ;
    endcase
  end

  kfpu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (opa_q),
    .den_i   (opb_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .sat_o   (div_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      ex_q      <= UW_NOP;
      started_q <= 1'b0;
      sat_q     <= 1'b0;
      zero_q    <= 1'b0;
    end else if (in_acc) begin
      unique case (in_data_i.action)
        ACT_PREDICT: pc_q <= ADDR_PREDICT;
        ACT_UPDATE:  pc_q <= ADDR_UPDATE;
        ACT_INIT:    pc_q <= ADDR_INIT;
        default:     pc_q <= ADDR_NONE;
      endcase
      ex_q      <= UW_NOP;
      started_q <= 1'b0;
      sat_q     <= 1'b0;
      zero_q    <= 1'b0;
    end else if (run) begin
      if (div_start) begin
        started_q <= 1'b1;
      end else if (div_done) begin
        started_q <= 1'b0;
      end
      if (wr_en && res[32]) begin
        sat_q <= 1'b1;
      end
      if (jump) begin
        zero_q <= 1'b1;
      end
      if (!ex_stall) begin
        // flush the word behind a taken jump
        pc_q <= jump ? ex_q.tgt : pc_q + 1'b1;
        ex_q <= jump ? UW_NOP : fw;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (run && !ex_stall) begin
      opa_q <= opa_d;
      opb_q <= opb_d;
    end
    if (run) begin
      if (ex_q.mul) begin
        prod_q <= $signed(opa_q) * $signed(opb_q);
      end
      if (ex_q.op == U_LD) begin
        acc_q <= prod_q;
      end else if (ex_q.op == U_ACC) begin
        if (sum65[64] != sum65[63]) begin
          acc_q <= sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          acc_q <= sum65[63:0];
        end
      end
    end
  end

  // ---- register writes: state, scratch and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      p_q <= {32'd65536, 32'd0, 32'd0, 32'd65536};
      y_q <= '0;
      f_q <= {32'd65536, 32'd0, 32'd0, 32'd65536};
      q_q <= '0;
      h_q <= {32'd0, 32'd65536};
      r_q <= '0;
    end else begin
      if (in_acc) begin
        y_q <= '0;
      end else if (run && wr_en) begin
        case (ex_q.dst)
          R_X0:  x_q[0] <= res[31:0];
          R_X1:  x_q[1] <= res[31:0];
          R_P00: p_q[0] <= res[31:0];
          R_P01: p_q[1] <= res[31:0];
          R_P10: p_q[2] <= res[31:0];
          R_P11: p_q[3] <= res[31:0];
          R_Y:   y_q    <= res[31:0];
          default: ;
        endcase
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_TRANS_ROW0:  {f_q[0], f_q[1]} <= cfg_data_i;
          CFG_TRANS_ROW1:  {f_q[2], f_q[3]} <= cfg_data_i;
          CFG_PNOISE_ROW0: {q_q[0], q_q[1]} <= cfg_data_i;
          CFG_PNOISE_ROW1: {q_q[2], q_q[3]} <= cfg_data_i;
          CFG_MEAS_ROW:    {h_q[0], h_q[1]} <= cfg_data_i;
          CFG_MEAS_NOISE:  r_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run && wr_en) begin
      case (ex_q.dst)
        R_T0: t_q[0] <= res[31:0];
        R_T1: t_q[1] <= res[31:0];
        R_T2: t_q[2] <= res[31:0];
        R_T3: t_q[3] <= res[31:0];
        R_T4: t_q[4] <= res[31:0];
        R_T5: t_q[5] <= res[31:0];
        R_T6: t_q[6] <= res[31:0];
        R_T7: t_q[7] <= res[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // ---- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (run && (ex_q.op == U_END)) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run && (ex_q.op == U_END)) begin
      out_q.step_kind  <= in_q.action;
      out_q.residual   <= y_q;
      out_q.est_out_0  <= x_q[0];
      out_q.est_out_1  <= x_q[1];
      out_q.cov_out_00 <= p_q[0];
      out_q.cov_out_01 <= p_q[1];
      out_q.cov_out_10 <= p_q[2];
      out_q.cov_out_11 <= p_q[3];
      out_q.status     <= zero_q ? ST_ZERO : (sat_q ? ST_SAT : ST_OK);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (run && (ex_q.op == U_DIV)))
    else $error("divider busy outside a divide step");
  a_no_accept_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |-> in_stall_o)
    else $error("input accepted while running");
  a_zero_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_ZERO)) |->
      (out_data_o.step_kind == ACT_UPDATE))
    else $error("zero variance status on non-update");
`endif

endmodule
